// ===== src/time_bin_decimator_defines.svh =====
// Assertion macros for the time bin decimator.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef TIME_BIN_DECIMATOR_DEFINES_SVH
`define TIME_BIN_DECIMATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is low
`define TBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define TBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/tbd_pkg.sv =====
// Shared types and constants of the time bin decimator.
// No dependencies; imported by time_bin_decimator.
`timescale 1ns / 1ps
`default_nettype none

package tbd_pkg;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PHASE = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    // Register widths and reset values
    localparam int PHASE_W = 24;
    localparam int WIDTH_W = 24;
    localparam int MODE_W  = 2;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 24'd2880;

    // Doubled distance to bin center never exceeds the width
    localparam int DIST_W = WIDTH_W + 1;

    // Selection modes; the unused code behaves as first in bin
    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LAST    = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB,
        S_ABS,
        S_DIV,
        S_BIN,
        S_MOD,
        S_DIST,
        S_ABSD,
        S_DECIDE,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

// ===== src/time_bin_decimator.sv =====
// Time bin decimator: one subtractor shared under a sequencer, APB configuration.
// Depends on tbd_pkg and time_bin_decimator_defines.svh.
//
// Keeps one sample per time bin, bin = floor((time - bin_phase) / bin_width). Each sample
// is one stream transfer and is worked in steps: one subtract for the offset, one for its
// magnitude, one restoring division step per dividend bit, then bin, offset-in-bin and
// doubled-distance fix-ups, all on the same subtractor, and a decision step.
// s_axis_tready is high only between samples. A closed bin and the episode flush each
// leave through the output register; the block waits in its decision or flush step
// while that register is still full, but a new sample is taken while a finished
// result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "time_bin_decimator_defines.svh"

module time_bin_decimator #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // Sample stream
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // [TIME_BITS-1:0] sample_time, next VALUE_BITS sample_value, zero pad to bytes
    input  wire logic [((TIME_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                                      s_axis_tlast,   // episode_end
    // Kept sample stream
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // [TIME_BITS-1:0] kept_time, next VALUE_BITS kept_value, zero pad to bytes
    output logic      [((TIME_BITS+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                                           m_axis_tlast,   // run_last
    // Configuration
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [tbd_pkg::APB_AW-1:0]                paddr,
    input  wire logic [tbd_pkg::APB_DW-1:0]                pwdata,
    output logic      [tbd_pkg::APB_DW-1:0]                prdata,
    output logic                                           pready
);

    import tbd_pkg::*;

    localparam int TD_W = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;
    // Offset time - phase needs one bit over the wider of time and phase
    localparam int AW   = ((TIME_BITS > PHASE_W + 1) ? TIME_BITS : PHASE_W + 1) + 1;
    // Magnitude of the offset fits in one bit less
    localparam int DB   = AW - 1;
    localparam int CW   = $clog2(DB);

    // Configuration registers
    logic [PHASE_W-1:0] r_phase;
    logic [WIDTH_W-1:0] r_width;
    logic [MODE_W-1:0]  r_mode;

    // Control
    t_state             r_state, n_state;
    logic               r_holding, n_holding;
    logic               r_m_valid, n_m_valid;
    logic [CW-1:0]      r_cnt, n_cnt;

    // Sample in work
    logic signed [TIME_BITS-1:0] r_t, n_t;
    logic [VALUE_BITS-1:0]       r_v, n_v;
    logic                        r_end, n_end;

    // Datapath
    logic [AW-1:0]       r_acc, n_acc;
    logic                r_neg, n_neg;
    logic [DB-1:0]       r_dq, n_dq;
    logic [WIDTH_W-1:0]  r_rem, n_rem;
    logic [AW-1:0]       r_bin, n_bin;
    logic [WIDTH_W-1:0]  r_m, n_m;
    logic [DIST_W-1:0]   r_dist, n_dist;

    // Held representative
    logic [AW-1:0]               r_held_bin, n_held_bin;
    logic [DIST_W-1:0]           r_held_dist, n_held_dist;
    logic signed [TIME_BITS-1:0] r_held_time, n_held_time;
    logic [VALUE_BITS-1:0]       r_held_value, n_held_value;

    // Output register
    logic signed [TIME_BITS-1:0] r_out_time, n_out_time;
    logic [VALUE_BITS-1:0]       r_out_value, n_out_value;
    logic                        r_out_last, n_out_last;

    // Shared subtractor: a - b - cin
    logic [AW-1:0] u_a, u_b, u_res;
    logic          u_cin;

    logic [WIDTH_W-1:0] w_eff;
    logic               out_free;
    logic               rem_nz;
    logic               new_bin;
    logic               take;
    logic               cfg_wr;

    assign u_res    = u_a - u_b - {{(AW-1){1'b0}}, u_cin};
    // A zero width acts as one
    assign w_eff    = (r_width == '0) ? {{(WIDTH_W-1){1'b0}}, 1'b1} : r_width;
    assign out_free = !r_m_valid || m_axis_tready;
    assign rem_nz   = (r_rem != '0);
    assign new_bin  = !r_holding || (r_bin != r_held_bin);

    // Replacement rule inside the held bin
    always_comb begin
        case (r_mode)
            MODE_LAST:    take = 1'b1;
            MODE_NEAREST: take = (r_dist < r_held_dist) ||
                                 ((r_dist == r_held_dist) && (r_t < r_held_time));
            default:      take = 1'b0;
        endcase
    end

    // Sequencer: next state, subtractor operands, datapath updates
    always_comb begin
        n_state      = r_state;
        n_holding    = r_holding;
        n_m_valid    = r_m_valid;
        n_cnt        = r_cnt;
        n_t          = r_t;
        n_v          = r_v;
        n_end        = r_end;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_dq         = r_dq;
        n_rem        = r_rem;
        n_bin        = r_bin;
        n_m          = r_m;
        n_dist       = r_dist;
        n_held_bin   = r_held_bin;
        n_held_dist  = r_held_dist;
        n_held_time  = r_held_time;
        n_held_value = r_held_value;
        n_out_time   = r_out_time;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        u_a          = '0;
        u_b          = '0;
        u_cin        = 1'b0;

        // Output transfer empties the register
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_t     = s_axis_tdata[TIME_BITS-1:0];
                    n_v     = s_axis_tdata[TIME_BITS +: VALUE_BITS];
                    n_end   = s_axis_tlast;
                    n_state = S_SUB;
                end
            end
            // Offset from the bin grid
            S_SUB: begin
                u_a     = {{(AW-TIME_BITS){r_t[TIME_BITS-1]}}, r_t};
                u_b     = {{(AW-PHASE_W){1'b0}}, r_phase};
                n_acc   = u_res;
                n_neg   = u_res[AW-1];
                n_state = S_ABS;
            end
            // Magnitude of the offset feeds the divider
            S_ABS: begin
                u_b     = r_acc;
                n_dq    = r_neg ? u_res[DB-1:0] : r_acc[DB-1:0];
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            // One restoring step per dividend bit; quotient shifts into r_dq
            S_DIV: begin
                u_a = {{(AW-WIDTH_W-1){1'b0}}, r_rem, r_dq[DB-1]};
                u_b = {{(AW-WIDTH_W){1'b0}}, w_eff};
                if (!u_res[AW-1]) begin
                    n_rem = u_res[WIDTH_W-1:0];
                    n_dq  = {r_dq[DB-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[WIDTH_W-2:0], r_dq[DB-1]};
                    n_dq  = {r_dq[DB-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(DB - 1)) begin
                    n_state = S_BIN;
                end
            end
            // Floor: negative offset with a remainder rounds one bin further down
            S_BIN: begin
                u_b     = {1'b0, r_dq};
                u_cin   = rem_nz;
                n_bin   = r_neg ? u_res : {1'b0, r_dq};
                n_state = S_MOD;
            end
            // Offset inside the bin
            S_MOD: begin
                u_a     = {{(AW-WIDTH_W){1'b0}}, w_eff};
                u_b     = {{(AW-WIDTH_W){1'b0}}, r_rem};
                n_m     = (r_neg && rem_nz) ? u_res[WIDTH_W-1:0] : r_rem;
                n_state = S_DIST;
            end
            // Doubled signed distance to the bin center
            S_DIST: begin
                u_a     = {{(AW-WIDTH_W-1){1'b0}}, r_m, 1'b0};
                u_b     = {{(AW-WIDTH_W){1'b0}}, w_eff};
                n_acc   = u_res;
                n_state = S_ABSD;
            end
            S_ABSD: begin
                u_b     = r_acc;
                n_dist  = r_acc[AW-1] ? u_res[DIST_W-1:0] : r_acc[DIST_W-1:0];
                n_state = S_DECIDE;
            end
            // Close the old bin or update the held sample
            S_DECIDE: begin
                if (out_free) begin
                    if (new_bin) begin
                        if (r_holding) begin
                            n_m_valid   = 1'b1;
                            n_out_time  = r_held_time;
                            n_out_value = r_held_value;
                            n_out_last  = 1'b0;
                        end
                        n_holding    = 1'b1;
                        n_held_bin   = r_bin;
                        n_held_dist  = r_dist;
                        n_held_time  = r_t;
                        n_held_value = r_v;
                    end else if (take) begin
                        n_held_dist  = r_dist;
                        n_held_time  = r_t;
                        n_held_value = r_v;
                    end
                    n_state = r_end ? S_FLUSH : S_IDLE;
                end
            end
            // Episode end: send the held sample marked last
            S_FLUSH: begin
                if (out_free) begin
                    n_m_valid   = 1'b1;
                    n_out_time  = r_held_time;
                    n_out_value = r_held_value;
                    n_out_last  = 1'b1;
                    n_holding   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_holding <= 1'b0;
            r_m_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_holding <= n_holding;
            r_m_valid <= n_m_valid;
            r_cnt     <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_t          <= n_t;
        r_v          <= n_v;
        r_end        <= n_end;
        r_acc        <= n_acc;
        r_neg        <= n_neg;
        r_dq         <= n_dq;
        r_rem        <= n_rem;
        r_bin        <= n_bin;
        r_m          <= n_m;
        r_dist       <= n_dist;
        r_held_bin   <= n_held_bin;
        r_held_dist  <= n_held_dist;
        r_held_time  <= n_held_time;
        r_held_value <= n_held_value;
        r_out_time   <= n_out_time;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    // Configuration writes
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_width <= WIDTH_RESET;
            r_mode  <= MODE_NEAREST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PHASE: r_phase <= pwdata[PHASE_W-1:0];
                REG_WIDTH: r_width <= pwdata[WIDTH_W-1:0];
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        case (paddr[3:2])
            REG_PHASE: prdata = {{(APB_DW-PHASE_W){1'b0}}, r_phase};
            REG_WIDTH: prdata = {{(APB_DW-WIDTH_W){1'b0}}, r_width};
            REG_MODE:  prdata = {{(APB_DW-MODE_W){1'b0}}, r_mode};
            default:   prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = TD_W'({r_out_value, r_out_time});
    assign m_axis_tlast  = r_out_last;

    // Divider remainder always stays below the width
    `TBD_ASSERT_IMPLY(a_rem_below_width, i_clk, i_rst_n,
        r_state == S_DIV, r_rem < w_eff, "divider remainder not below bin width")

    // Doubled distance to the center is bounded by the width
    `TBD_ASSERT_IMPLY(a_dist_bounded, i_clk, i_rst_n,
        r_state == S_DECIDE, r_dist <= {1'b0, w_eff}, "distance exceeds bin width")

    // A flush only happens with a sample held
    `TBD_ASSERT_IMPLY(a_flush_holding, i_clk, i_rst_n,
        r_state == S_FLUSH, r_holding, "flush without a held sample")

    // A flush leaves a last-marked result and nothing held
    `TBD_ASSERT_NEXT(a_flush_result, i_clk, i_rst_n,
        (r_state == S_FLUSH) && out_free,
        r_m_valid && r_out_last && !r_holding, "flush did not load a last result")

endmodule

`default_nettype wire
